// ===== design/i2c_power_sleep_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the power and sleep controller.
// Each macro expands to a labeled concurrent assertion clocked on aclk and
// held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef I2C_POWER_SLEEP_CONTROLLER_TOP_MACROS_SVH
`define I2C_POWER_SLEEP_CONTROLLER_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define PSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that implies another one at the same clock edge.
`define PSC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another one at the next clock edge.
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Types, constants and helper functions of the power and sleep controller.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

    // Register file geometry.
    localparam int unsigned REG_COUNT = 5;
    localparam int unsigned PTR_W     = 3;
    localparam int unsigned BYTE_W    = 8;

    // Fixed register roles.
    localparam logic [PTR_W-1:0] LIGHT_IDX = 3'd0;
    localparam logic [PTR_W-1:0] POWER_IDX = 3'd1;
    localparam logic [PTR_W-1:0] MULT_IDX  = 3'd2;
    localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(REG_COUNT - 1);

    // Power-off timeout.
    localparam int unsigned TIMEOUT_W = 17;
    localparam int unsigned TICK_STEP = 8;
    localparam logic [TIMEOUT_W-1:0] STEP_VAL   = TIMEOUT_W'(TICK_STEP);
    localparam logic [TIMEOUT_W-1:0] ROUND_ADD  = 17'd7;
    localparam logic [TIMEOUT_W-1:0] ROUND_MASK = ~17'd7;

    // LED effect.
    localparam int unsigned EFFECT_TICKS = 500;
    localparam int unsigned COUNT_W      = 9;
    localparam logic [COUNT_W-1:0] EFFECT_LAST = COUNT_W'(EFFECT_TICKS);
    localparam logic [BYTE_W-1:0]  EFFECT_RED   = 8'd128;
    localparam logic [BYTE_W-1:0]  EFFECT_WHITE = 8'd64;

    // Reciprocal used to reduce a byte modulo REG_COUNT.
    localparam int unsigned RECIP_W = 16;
    localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'((1 << RECIP_W) / REG_COUNT);

    // Item kinds carried on the input tuser.
    typedef enum logic [2:0] {
        CMD_PTR_WRITE  = 3'd0,
        CMD_DATA_WRITE = 3'd1,
        CMD_READ       = 3'd2,
        CMD_BUS_STOP   = 3'd3,
        CMD_WDOG_TICK  = 3'd4,
        CMD_ACCEL      = 3'd5,
        CMD_FX_TICK    = 3'd6
    } cmd_t;

    typedef logic [BYTE_W-1:0] byte_t;

    // Output payload, members listed from the highest bit down.
    typedef struct packed {
        byte_t led_white;
        byte_t led_blue;
        byte_t led_green;
        byte_t led_red;
        logic  led_update;
        logic  effect_playing;
        logic  partner_off;
        byte_t read_data;
    } result_t;

    // Power-up contents of the register file: multiplier 1, last register 0xEF.
    function automatic byte_t reg_reset_value(input int unsigned idx);
        byte_t val;
        val = '0;
        if (idx == 32'(MULT_IDX)) begin
            val = 8'h01;
        end else if (idx == 32'(LAST_IDX)) begin
            val = 8'hEF;
        end
        return val;
    endfunction

    // Next register pointer with wrap.
    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
        return (ptr == LAST_IDX) ? '0 : ptr + PTR_W'(1);
    endfunction

    // Byte modulo REG_COUNT by reciprocal multiply and one correction.
    function automatic logic [PTR_W-1:0] ptr_from_byte(input byte_t data);
        logic [BYTE_W+RECIP_W-1:0] prod;
        byte_t                     quot;
        byte_t                     rem;
        prod = {{RECIP_W{1'b0}}, data} * {{BYTE_W{1'b0}}, MOD_RECIP};
        quot = prod[BYTE_W+RECIP_W-1:RECIP_W];
        rem  = data - BYTE_W'(quot * BYTE_W'(REG_COUNT));
        if (rem >= BYTE_W'(REG_COUNT)) begin
            rem = rem - BYTE_W'(REG_COUNT);
        end
        return rem[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/i2c_power_sleep_controller_top.sv =====
// A result is registered and appears on the m_ side in the cycle after its item is accepted.
// One item per cycle while the result is not stalled; all state is updated in the accepting cycle.
// A new item is taken in the cycle the previous result leaves; a stalled result holds it off.
// Reset (aresetn low, synchronous) restores the register file to 0,0,1,0,0xEF,
// clears pointer, timeout, power and effect state, and empties the result stage.
// ----------------------------------------------------------------------------
// i2c_power_sleep_controller_top
// Bus slave register file with auto-incrementing pointer, power-off timer
// driven by watchdog ticks and accelerometer events, and an LED effect timer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_power_sleep_controller_top_macros.svh"

module i2c_power_sleep_controller_top
    import psc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data
    input  wire logic [2:0]  s_tuser,   // [2:0] cmd
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] read_data, [8] partner_off,
                                        // [9] effect_playing, [10] led_update,
                                        // [18:11] led_red, [26:19] led_green,
                                        // [34:27] led_blue, [42:35] led_white,
                                        // [47:43] zero
    output logic             m_tuser    // [0] read_valid
);

    // State.
    byte_t                regs_reg [REG_COUNT];
    byte_t                regs_next [REG_COUNT];
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                 off_reg, off_next;
    logic                 accel_en_reg, accel_en_next;
    logic                 accel_pend_reg, accel_pend_next;
    logic                 playing_reg, playing_next;
    logic [COUNT_W-1:0]   fx_count_reg, fx_count_next;

    // Result stage.
    logic                 out_valid_reg;
    result_t              out_data_reg, out_data_next;
    logic                 out_rv_reg, out_rv_next;

    logic                 accept;
    cmd_t                 cmd;
    byte_t                data;
    logic [2*BYTE_W-1:0]  power_prod;
    logic [TIMEOUT_W-1:0] power_time;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign data     = s_tdata;

    // Power-off time: power times multiplier, rounded up to a multiple of eight.
    assign power_prod = regs_reg[POWER_IDX] * regs_reg[MULT_IDX];
    assign power_time = ({1'b0, power_prod} + ROUND_ADD) & ROUND_MASK;

    // Command decode and next state.
    always_comb begin
        regs_next       = regs_reg;
        ptr_next        = ptr_reg;
        timeout_next    = timeout_reg;
        off_next        = off_reg;
        accel_en_next   = accel_en_reg;
        accel_pend_next = accel_pend_reg;
        playing_next    = playing_reg;
        fx_count_next   = fx_count_reg;
        out_data_next   = '0;
        out_rv_next     = 1'b0;

        unique case (cmd)
            CMD_PTR_WRITE: begin
                if (!off_reg) begin
                    ptr_next = ptr_from_byte(data);
                end
            end
            CMD_DATA_WRITE: begin
                if (!off_reg) begin
                    regs_next[ptr_reg] = data;
                    ptr_next           = ptr_advance(ptr_reg);
                end
            end
            CMD_READ: begin
                if (!off_reg) begin
                    out_data_next.read_data = regs_reg[ptr_reg];
                    out_rv_next             = 1'b1;
                    ptr_next                = ptr_advance(ptr_reg);
                end
            end
            CMD_BUS_STOP: begin
                if (!off_reg) begin
                    if (regs_reg[LIGHT_IDX] != '0) begin
                        regs_next[LIGHT_IDX] = '0;
                        playing_next         = 1'b1;
                        fx_count_next        = '0;
                    end
                    if (regs_reg[POWER_IDX] != '0) begin
                        timeout_next         = power_time;
                        regs_next[POWER_IDX] = '0;
                        accel_en_next        = 1'b1;
                        off_next             = 1'b1;
                    end
                end
            end
            CMD_WDOG_TICK: begin
                timeout_next = (timeout_reg >= STEP_VAL) ? timeout_reg - STEP_VAL : '0;
                if (off_reg && timeout_next == '0) begin
                    timeout_next    = '0;
                    accel_en_next   = 1'b0;
                    accel_pend_next = 1'b0;
                    off_next        = 1'b0;
                end
            end
            CMD_ACCEL: begin
                if (accel_en_reg) begin
                    accel_pend_next = 1'b1;
                end
                if (off_reg && accel_pend_next) begin
                    timeout_next    = '0;
                    accel_en_next   = 1'b0;
                    accel_pend_next = 1'b0;
                    off_next        = 1'b0;
                end
            end
            CMD_FX_TICK: begin
                if (playing_reg) begin
                    out_data_next.led_update = 1'b1;
                    if (fx_count_reg < EFFECT_LAST) begin
                        out_data_next.led_red   = EFFECT_RED;
                        out_data_next.led_white = EFFECT_WHITE;
                        fx_count_next           = fx_count_reg + COUNT_W'(1);
                    end else begin
                        playing_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        out_data_next.partner_off    = off_next;
        out_data_next.effect_playing = playing_next;
    end

    // State registers, updated on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                regs_reg[i] <= reg_reset_value(i);
            end
            ptr_reg        <= '0;
            timeout_reg    <= '0;
            off_reg        <= 1'b0;
            accel_en_reg   <= 1'b0;
            accel_pend_reg <= 1'b0;
            playing_reg    <= 1'b0;
            fx_count_reg   <= '0;
        end else if (accept) begin
            regs_reg       <= regs_next;
            ptr_reg        <= ptr_next;
            timeout_reg    <= timeout_next;
            off_reg        <= off_next;
            accel_en_reg   <= accel_en_next;
            accel_pend_reg <= accel_pend_next;
            playing_reg    <= playing_next;
            fx_count_reg   <= fx_count_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
            out_rv_reg   <= out_rv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};
    assign m_tuser  = out_rv_reg;

    // Checks.
    `PSC_ASSERT_ALWAYS(a_ptr_range, ptr_reg <= LAST_IDX, "register pointer out of range")
    `PSC_ASSERT_IMPLY(a_on_idle, !off_reg, timeout_reg == '0 && !accel_en_reg && !accel_pend_reg,
        "power timer active while partner is on")
    `PSC_ASSERT_IMPLY(a_read_on, m_tvalid && m_tuser, !m_tdata[8],
        "read result while partner is off")
    `PSC_ASSERT_IMPLY(a_led_quiet, m_tvalid && !m_tdata[10], m_tdata[42:11] == '0,
        "LED colors without an update")
    `PSC_ASSERT_ALWAYS(a_fx_range, fx_count_reg <= EFFECT_LAST, "effect count past its end")
    `PSC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result dropped or changed while stalled")

endmodule

`default_nettype wire

// ===== test/tb_i2c_power_sleep_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_power_sleep_controller_top
// Self-checking bench for the power and sleep controller. A shadow copy of
// the register file, pointer, power-off timer and LED effect predicts the
// result of every accepted item. Each result is then compared field by field
// in arrival order. Stimulus is a short directed sequence, one full LED
// effect, and random bus transactions mixed with ticks. The sender idles in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_i2c_power_sleep_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    // The one item kind the block does not decode.
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int unsigned ITEM_TARGET = 1650;
    localparam int unsigned HANG_LIMIT  = 1000;
    localparam int unsigned FX_RUN_TICKS = 504;

    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_LONG_STALL
    } rx_mode_t;

    // One predicted result: the payload and the read flag on tuser.
    typedef struct {
        result_t    res;
        logic       rd_valid;
    } due_t;

    // Shadow of the controller state and the queue of results it predicts.
    class sleep_ctl_shadow;
        byte_t                regs [8];
        logic [PTR_W-1:0]     ptr;
        logic [TIMEOUT_W-1:0] timeout;
        bit                   partner_down;
        bit                   accel_armed;
        bit                   accel_seen;
        bit                   fx_on;
        logic [COUNT_W-1:0]   fx_count;
        due_t                 due_q [$];
        int unsigned          errors;
        int unsigned          accepted;
        int unsigned          checked;
        int unsigned          reads;
        int unsigned          sleeps;
        int unsigned          wakes;
        int unsigned          fx_ends;

        function new();
            foreach (regs[i]) begin
                regs[i] = '0;
            end
            regs[MULT_IDX] = 8'h01;
            regs[LAST_IDX] = 8'hEF;
            ptr          = '0;
            timeout      = '0;
            partner_down = 1'b0;
            accel_armed  = 1'b0;
            accel_seen   = 1'b0;
            fx_on        = 1'b0;
            fx_count     = '0;
            errors       = 0;
            accepted     = 0;
            checked      = 0;
            reads        = 0;
            sleeps       = 0;
            wakes        = 0;
            fx_ends      = 0;
        endfunction

        function logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
            return (32'(p) + 1 >= REG_COUNT) ? '0 : p + 1'b1;
        endfunction

        function void power_up();
            timeout      = '0;
            accel_armed  = 1'b0;
            accel_seen   = 1'b0;
            partner_down = 1'b0;
            wakes++;
        endfunction

        // Applies one accepted item and queues its result. Returns 0 when the
        // block simply drops the item.
        function bit take_item(logic [2:0] kind, byte_t data);
            due_t                 e;
            logic [TIMEOUT_W-1:0] prod;
            bit                   live;
            e.res      = '0;
            e.rd_valid = 1'b0;
            live       = 1'b1;
            accepted++;
            case (kind)
                CMD_PTR_WRITE: begin
                    if (partner_down) live = 1'b0;
                    else ptr = PTR_W'(32'(data) % REG_COUNT);
                end
                CMD_DATA_WRITE: begin
                    if (partner_down) begin
                        live = 1'b0;
                    end else begin
                        regs[ptr] = data;
                        ptr       = next_ptr(ptr);
                    end
                end
                CMD_READ: begin
                    if (partner_down) begin
                        live = 1'b0;
                    end else begin
                        e.res.read_data = regs[ptr];
                        e.rd_valid      = 1'b1;
                        ptr             = next_ptr(ptr);
                        reads++;
                    end
                end
                CMD_BUS_STOP: begin
                    if (partner_down) begin
                        live = 1'b0;
                    end else begin
                        if (regs[LIGHT_IDX] != 0) begin
                            regs[LIGHT_IDX] = '0;
                            fx_on           = 1'b1;
                            fx_count        = '0;
                        end
                        if (regs[POWER_IDX] != 0) begin
                            // Off time is power times multiplier, rounded up to 8.
                            prod = TIMEOUT_W'(regs[POWER_IDX]) * TIMEOUT_W'(regs[MULT_IDX]);
                            if (prod[2:0] != 0) begin
                                prod = {prod[TIMEOUT_W-1:3], 3'b000} + TIMEOUT_W'(8);
                            end
                            timeout          = prod;
                            regs[POWER_IDX]  = '0;
                            accel_armed      = 1'b1;
                            partner_down     = 1'b1;
                            sleeps++;
                        end
                    end
                end
                CMD_WDOG_TICK: begin
                    if (32'(timeout) >= TICK_STEP) timeout = timeout - TIMEOUT_W'(TICK_STEP);
                    else timeout = '0;
                    if (partner_down && timeout == 0) power_up();
                end
                CMD_ACCEL: begin
                    if (accel_armed) accel_seen = 1'b1;
                    if (partner_down && accel_seen) power_up();
                end
                CMD_FX_TICK: begin
                    if (fx_on) begin
                        e.res.led_update = 1'b1;
                        if (32'(fx_count) < EFFECT_TICKS) begin
                            e.res.led_red   = EFFECT_RED;
                            e.res.led_white = EFFECT_WHITE;
                            fx_count        = fx_count + 1'b1;
                        end else begin
                            fx_on = 1'b0;
                            fx_ends++;
                        end
                    end
                end
                default: begin
                    live = 1'b0;
                end
            endcase
            e.res.partner_off    = partner_down;
            e.res.effect_playing = fx_on;
            due_q.push_back(e);
            return live;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted result against the oldest prediction.
        function void match_result(logic [47:0] tdata, logic tuser);
            due_t    e;
            result_t got;
            got = result_t'(tdata[$bits(result_t)-1:0]);
            if (due_q.size() == 0) begin
                $error("result with no item waiting: tdata=%h tuser=%b", tdata, tuser);
                errors++;
                return;
            end
            e = due_q.pop_front();
            checked++;
            compare_field("read_data", e.res.read_data, got.read_data);
            compare_field("read_valid", e.rd_valid, tuser);
            compare_field("partner_off", e.res.partner_off, got.partner_off);
            compare_field("effect_playing", e.res.effect_playing, got.effect_playing);
            compare_field("led_update", e.res.led_update, got.led_update);
            compare_field("led_red", e.res.led_red, got.led_red);
            compare_field("led_green", e.res.led_green, got.led_green);
            compare_field("led_blue", e.res.led_blue, got.led_blue);
            compare_field("led_white", e.res.led_white, got.led_white);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    sleep_ctl_shadow shadow = new();
    int unsigned     live_items = 0;
    int unsigned     burst_left = 0;

    i2c_power_sleep_controller_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Presents one item from a falling edge and holds it until accepted.
    // A new burst may open with a gap in which tvalid is low.
    task automatic send_item(input logic [2:0] kind, input byte_t data);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (shadow.take_item(kind, data)) live_items++;
        @(negedge aclk);
    endtask

    // Holds the sender off until every predicted result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (shadow.due_q.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    // Result checking at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            shadow.match_result(m_tdata, m_tuser);
        end
    end

    // Receiver back-pressure: a pattern drawn at random, redrawn when its run ends.
    initial begin : rx_pacing
        rx_mode_t    mode;
        int unsigned left;
        int unsigned hold;
        m_tready = 1'b0;
        mode     = RX_OPEN;
        left     = 0;
        hold     = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(32, 200);
            end
            left--;
            case (mode)
                RX_OPEN: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= ($urandom_range(0, 1) == 1);
                end
                RX_EVERY_FOURTH: begin
                    m_tready <= (left[1:0] != 2'd0);
                end
                default: begin
                    if (hold > 0) begin
                        hold--;
                        m_tready <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        hold = $urandom_range(1, 10);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Ends the run when nothing moves on either side for too long.
    initial begin : hang_guard
        int unsigned quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet = 0;
            else quiet++;
        end
        $display("tb_i2c_power_sleep_controller_top failed");
        $finish;
    end

    // Stimulus.
    initial begin : stimulus
        int unsigned pick;
        int unsigned n;
        int unsigned fx_sent;
        bit          paused;
        byte_t       b;
        logic [2:0]  kind;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        paused   = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reads wrap past the last register back to the first.
        send_item(CMD_READ, 8'h00);
        send_item(CMD_PTR_WRITE, 8'd4);
        send_item(CMD_READ, 8'hFF);
        // A pointer byte of 255 lands on register 0.
        send_item(CMD_PTR_WRITE, 8'hFF);
        send_item(CMD_DATA_WRITE, 8'hFF);
        send_item(CMD_DATA_WRITE, 8'h05);
        // A zero multiplier gives a zero off time, yet the partner goes off.
        send_item(CMD_DATA_WRITE, 8'h00);
        send_item(CMD_BUS_STOP, 8'h00);
        // Bus items are dropped while the partner is off.
        send_item(CMD_READ, 8'h00);
        send_item(CMD_DATA_WRITE, 8'h11);
        send_item(CMD_ACCEL, 8'h00);
        send_item(CMD_FX_TICK, 8'h00);
        // An accelerometer event while powered is ignored.
        send_item(CMD_ACCEL, 8'hFF);
        // Largest off time: 255 times 255.
        send_item(CMD_PTR_WRITE, 8'd6);
        send_item(CMD_DATA_WRITE, 8'hFF);
        send_item(CMD_DATA_WRITE, 8'hFF);
        send_item(CMD_BUS_STOP, 8'hAA);
        send_item(CMD_WDOG_TICK, 8'h55);
        send_item(CMD_UNUSED, 8'hFF);
        send_item(CMD_ACCEL, 8'h00);
        // Smallest nonzero off time runs out on a single watchdog tick.
        send_item(CMD_PTR_WRITE, 8'd1);
        send_item(CMD_DATA_WRITE, 8'h03);
        send_item(CMD_DATA_WRITE, 8'h01);
        send_item(CMD_BUS_STOP, 8'h00);
        send_item(CMD_WDOG_TICK, 8'h00);
        wait_drained();

        // One LED effect played to its end, then a few ticks while idle.
        send_item(CMD_PTR_WRITE, 8'd0);
        send_item(CMD_DATA_WRITE, byte_t'($urandom_range(1, 255)));
        send_item(CMD_BUS_STOP, byte_t'($urandom));
        fx_sent = 0;
        while (fx_sent < FX_RUN_TICKS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(CMD_READ, byte_t'($urandom));
            end else begin
                send_item(CMD_FX_TICK, byte_t'($urandom));
                fx_sent++;
            end
        end

        // Random bus transactions, tick runs and noise.
        while (shadow.accepted < ITEM_TARGET) begin
            if (!paused && shadow.accepted >= ITEM_TARGET / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // Register write transaction, usually closed by a bus stop.
                b = ($urandom_range(0, 3) == 0) ? byte_t'($urandom)
                                                : byte_t'($urandom_range(0, 4));
                send_item(CMD_PTR_WRITE, b);
                n = $urandom_range(1, 7);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: b = 8'h00;
                        1: b = byte_t'($urandom_range(1, 4));
                        default: b = byte_t'($urandom);
                    endcase
                    send_item(CMD_DATA_WRITE, b);
                end
                if ($urandom_range(0, 9) < 8) send_item(CMD_BUS_STOP, byte_t'($urandom));
            end else if (pick < 55) begin
                // Register read transaction.
                if ($urandom_range(0, 3) != 0) begin
                    send_item(CMD_PTR_WRITE, byte_t'($urandom));
                end
                n = $urandom_range(1, 7);
                repeat (n) send_item(CMD_READ, byte_t'($urandom));
                if ($urandom_range(0, 1) == 0) send_item(CMD_BUS_STOP, byte_t'($urandom));
            end else if (pick < 85) begin
                // Run of watchdog, accelerometer and effect ticks.
                n = $urandom_range(1, 12);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) kind = CMD_WDOG_TICK;
                    else if (pick < 65) kind = CMD_ACCEL;
                    else kind = CMD_FX_TICK;
                    send_item(kind, byte_t'($urandom));
                end
            end else begin
                send_item(3'($urandom_range(0, 7)), byte_t'($urandom));
            end
        end

        wait_drained();
        repeat (4) @(negedge aclk);
        $display("Run: %0d items accepted (%0d acted on), %0d reads, %0d power-downs, %0d wake-ups.",
                 shadow.accepted, live_items, shadow.reads, shadow.sleeps, shadow.wakes);
        $display("LED effect finished %0d times; %0d results checked, %0d mismatches.",
                 shadow.fx_ends, shadow.checked, shadow.errors);
        if (shadow.errors == 0) begin
            $display("tb_i2c_power_sleep_controller_top passed");
        end else begin
            $display("tb_i2c_power_sleep_controller_top failed");
        end
        $finish;
    end

endmodule

// ===== i2c_power_sleep_controller_top.f =====
+incdir+design
design/psc_pkg.sv
design/i2c_power_sleep_controller_top.sv
test/tb_i2c_power_sleep_controller_top.sv
